FILE: rtl/md5_hash_engine_assert.svh
// Assertion macros shared by the md5 checker.
`ifndef MD5_HASH_ENGINE_ASSERT_SVH
`define MD5_HASH_ENGINE_ASSERT_SVH

// same-cycle implication, checked on i_clk, off during reset
`define MD5_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("md5 assertion failed");

// next-cycle implication, checked on i_clk, off during reset
`define MD5_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("md5 assertion failed");

`endif

FILE: rtl/md5_pkg.sv
// Shared types, constants and round tables for the md5 hash engine.
`default_nettype none

package md5_pkg;

    localparam logic [3:0][31:0] MD5_IV = {
        32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic       we;
        logic [3:0] addr;
        logic [1:0] lane;
        logic [7:0] data;
    } t_mem_wr;

    function automatic logic [31:0] md5_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // message word index used by each round
    function automatic logic [3:0] md5_g(input logic [5:0] r);
        logic [3:0] v;
        logic [3:0] g;
        v = r[3:0];
        case (r[5:4])
            2'd0:    g = v;
            2'd1:    g = v * 4'd5 + 4'd1;
            2'd2:    g = v * 4'd3 + 4'd5;
            2'd3:    g = v * 4'd7;
            default: g = v;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/md5_blk_mem.sv
// Block buffer: 16 words of 32 bits, byte-lane write, registered word read.
`default_nettype none

module md5_blk_mem
    import md5_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_mem_wr     i_wr,
    input  wire logic [3:0]  i_raddr,
    output logic      [31:0] o_rdata
);

    logic [31:0] r_mem [16];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr][{i_wr.lane, 3'b000} +: 8] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/md5_round.sv
// One MD5 round step: produces the new b word from a, b, c, d and the message word.
`default_nettype none

module md5_round
    import md5_pkg::*;
(
    input  wire logic [5:0]  i_round,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic [31:0] i_c,
    input  wire logic [31:0] i_d,
    input  wire logic [31:0] i_w,
    output logic      [31:0] o_b
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] dbl;

    always_comb begin
        case (i_round[5:4])
            2'd0:    f = (i_b & i_c) | (~i_b & i_d);
            2'd1:    f = (i_d & i_b) | (~i_d & i_c);
            2'd2:    f = i_b ^ i_c ^ i_d;
            2'd3:    f = i_c ^ (i_b | ~i_d);
            default: f = '0;
        endcase
        sum = i_a + f + md5_k(i_round) + i_w;
        dbl = {sum, sum} << md5_s(i_round);
        o_b = i_b + dbl[63:32];
    end

endmodule

`default_nettype wire

FILE: rtl/md5_hash_engine.sv
// Streaming MD5 hasher top level: byte intake, padding sequencer and digest output.
//
// Input channel (i_valid / o_stall): an item is taken when i_valid is high and
// o_stall low. Op absorb carries one message byte; op finish closes the message.
// Output channel (o_valid / i_stall): four items per finish, h0..h3 with
// o_word_index 0..3, o_last_word set on h3. Payload holds while i_stall is high.
// An absorb is taken while the block is idle; the byte that fills a 64-byte
// block makes it busy for word prefetch, 64 rounds through the single round
// unit and chain add. A finish at fill count f pushes one pad byte per cycle,
// (64 - f) bytes if f < 56 else (128 - f), each full block compressed as above,
// then shows the four digest words, one per cycle when not stalled. Throughput
// is bounded by the round unit and the one write port of the block buffer.
// o_stall is high whenever the block is not idle.
// Reset (synchronous, active low) loads the initial chain value and clears the
// fill and byte counts; a message in progress is dropped.
`default_nettype none

module md5_hash_engine
    import md5_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [31:0] o_digest_word,
    output logic      [1:0]  o_word_index,
    output logic             o_last_word
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_PREF  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [5:0]        r_fill, n_fill;
    logic [63:0]       r_msg, n_msg;
    logic              r_fin, n_fin;
    logic              r_first, n_first;
    logic              r_lenph, n_lenph;
    logic [5:0]        r_round, n_round;
    logic [1:0]        r_word, n_word;
    logic [3:0][31:0]  r_h, n_h;
    logic [31:0]       r_a, r_b, r_c, r_d;
    logic [31:0]       n_a, n_b, n_c, n_d;

    t_mem_wr           mem_wr;
    logic [3:0]        raddr;
    logic [31:0]       rdata;
    logic [31:0]       round_b;
    logic [63:0]       bit_len;
    logic              push;

    md5_blk_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    md5_round u_round (
        .i_round (r_round),
        .i_a     (r_a),
        .i_b     (r_b),
        .i_c     (r_c),
        .i_d     (r_d),
        .i_w     (rdata),
        .o_b     (round_b)
    );

    assign bit_len = {r_msg[60:0], 3'b000};
    assign raddr   = (r_state == S_PREF) ? md5_g(6'd0) : md5_g(r_round + 6'd1);

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_msg   = r_msg;
        n_fin   = r_fin;
        n_first = r_first;
        n_lenph = r_lenph;
        n_round = r_round;
        n_word  = r_word;
        n_h     = r_h;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_d     = r_d;
        push    = 1'b0;
        mem_wr.we   = 1'b0;
        mem_wr.addr = r_fill[5:2];
        mem_wr.lane = r_fill[1:0];
        mem_wr.data = i_data_byte;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_FINISH) begin
                        n_fin   = 1'b1;
                        n_first = 1'b1;
                        n_lenph = 1'b0;
                        n_state = S_PAD;
                    end else begin
                        push  = 1'b1;
                        n_msg = r_msg + 64'd1;
                    end
                end
            end
            S_PAD: begin
                push    = 1'b1;
                n_first = 1'b0;
                if (r_first) begin
                    mem_wr.data = PAD_BYTE;
                end else if (r_lenph || r_fill == LEN_POS) begin
                    n_lenph     = 1'b1;
                    mem_wr.data = bit_len[{r_fill[2:0], 3'b000} +: 8];
                end else begin
                    mem_wr.data = 8'h00;
                end
            end
            S_PREF: begin
                n_a     = r_h[0];
                n_b     = r_h[1];
                n_c     = r_h[2];
                n_d     = r_h[3];
                n_round = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_a     = r_d;
                n_b     = round_b;
                n_c     = r_b;
                n_d     = r_c;
                n_round = r_round + 6'd1;
                if (r_round == LAST_POS) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_h[0] = r_h[0] + r_a;
                n_h[1] = r_h[1] + r_b;
                n_h[2] = r_h[2] + r_c;
                n_h[3] = r_h[3] + r_d;
                n_word = '0;
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_lenph) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (r_word == 2'd3) begin
                        n_h     = MD5_IV;
                        n_msg   = '0;
                        n_fin   = 1'b0;
                        n_lenph = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_word = r_word + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (push) begin
            mem_wr.we = 1'b1;
            n_fill    = r_fill + 6'd1;
            if (r_fill == LAST_POS) begin
                n_state = S_PREF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_msg   <= '0;
            r_fin   <= 1'b0;
            r_first <= 1'b0;
            r_lenph <= 1'b0;
            r_round <= '0;
            r_word  <= '0;
            r_h     <= MD5_IV;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_msg   <= n_msg;
            r_fin   <= n_fin;
            r_first <= n_first;
            r_lenph <= n_lenph;
            r_round <= n_round;
            r_word  <= n_word;
            r_h     <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_h[r_word];
    assign o_word_index  = r_word;
    assign o_last_word   = (r_word == 2'd3);

endmodule

`default_nettype wire

FILE: rtl/md5_chk.sv
// Port-level checker for the md5 hash engine and its bind.
`default_nettype none
`include "md5_hash_engine_assert.svh"

module md5_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        i_op,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_digest_word,
    input wire logic [1:0]  o_word_index,
    input wire logic        o_last_word
);

    `MD5_ASSERT_NOW(a_busy_while_out, o_valid, o_stall)
    `MD5_ASSERT_NEXT(a_finish_busy, i_valid && !o_stall && i_op, o_stall && !o_valid)
    `MD5_ASSERT_NOW(a_last_mark, o_valid, o_last_word == (o_word_index == 2'd3))
    `MD5_ASSERT_NEXT(a_word_order, o_valid && !i_stall && !o_last_word, o_valid && (o_word_index == $past(o_word_index) + 2'd1))
    `MD5_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_digest_word) && $stable(o_word_index))

endmodule

bind md5_hash_engine md5_chk u_md5_chk (.*);

`default_nettype wire

FILE: bench/md5_hash_engine_test.sv
// Testbench for md5_hash_engine: byte streams with random gaps, digests checked in order.
`timescale 1ns / 100ps

module md5_hash_engine_test;
    import md5_pkg::*;

    localparam int          RANDOM_ITEMS   = 470;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 100;
    localparam int          SHOWN_ERRORS   = 10;
    localparam logic [7:0]  PAD_MARK       = 8'h80;
    localparam int          LENGTH_SLOT    = 56;

    localparam logic [31:0] START_CHAIN [0:3] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] SINE_K [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // four shift amounts per 16-round quarter
    localparam int ROT_AMT [0:15] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                      4, 11, 16, 23, 6, 10, 15, 21};

    localparam int BOUNDARY_LEN [0:9] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } t_digest_item;

    class t_digest_board;
        logic [31:0]  chain [4];
        logic [7:0]   blk [64];
        int           fill;
        logic [63:0]  byte_count;
        t_digest_item digest_q [$];
        int           fails;

        function new();
            fails = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 4; i++) chain[i] = START_CHAIN[i];
            fill       = 0;
            byte_count = '0;
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, f, t, sum;
            int          g, s;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int r = 0; r < 64; r++) begin
                case (r / 16)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = r;
                    end
                    1: begin
                        f = (d & b) | (~d & c);
                        g = (5 * r + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = (3 * r + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = (7 * r) % 16;
                    end
                endcase
                s   = ROT_AMT[(r / 16) * 4 + (r % 4)];
                sum = a + f + SINE_K[r] + w[g];
                t   = d;
                d   = c;
                c   = b;
                b   = b + ((sum << s) | (sum >> (32 - s)));
                a   = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void push(logic [7:0] data);
            blk[fill] = data;
            fill++;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        endfunction

        function void note_item(logic op, logic [7:0] data);
            logic [63:0]  bit_len;
            t_digest_item item;
            if (op == OP_ABSORB) begin
                byte_count += 64'd1;
                push(data);
            end else begin
                bit_len = byte_count << 3;
                push(PAD_MARK);
                while (fill != LENGTH_SLOT) push(8'h00);
                for (int k = 0; k < 8; k++) push(bit_len[8*k +: 8]);
                for (int k = 0; k < 4; k++) begin
                    item.word  = chain[k];
                    item.index = k[1:0];
                    item.last  = (k == 3);
                    digest_q.push_back(item);
                end
                restart();
            end
        endfunction

        function void flag(string what);
            if (fails < SHOWN_ERRORS) $display("%0t: mismatch: %s", $realtime, what);
            fails++;
        endfunction

        function void check_word(logic [31:0] word, logic [1:0] index, logic last);
            t_digest_item want;
            if (digest_q.size() == 0) begin
                flag($sformatf("unexpected word %h index %0d last %0b", word, index, last));
                return;
            end
            want = digest_q.pop_front();
            if (word !== want.word || index !== want.index || last !== want.last)
                flag($sformatf("expected %h/%0d/%0b, got %h/%0d/%0b",
                               want.word, want.index, want.last, word, index, last));
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_op        = OP_ABSORB;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last_word;

    t_digest_board   board = new();
    bit              steady = 1'b0;
    int              items_sent = 0;
    int              idle_cycles = 0;

    md5_hash_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 7);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_word(o_digest_word, o_word_index, o_last_word);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("md5_hash_engine_test: FAIL");
            $finish;
        end
    end

    task automatic send_item(logic op, logic [7:0] data);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_stall);
        board.note_item(op, data);
        items_sent++;
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom_range(255)));
        send_item(OP_FINISH, 8'($urandom_range(255)));
    endtask

    function automatic int pick_length();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return $urandom_range(16);
        if (sel < 8) return BOUNDARY_LEN[$urandom_range(9)];
        return $urandom_range(130);
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, twice in a row, then short messages at the byte extremes
        send_item(OP_FINISH, 8'h00);
        send_item(OP_FINISH, 8'hff);
        send_item(OP_ABSORB, 8'h00);
        send_item(OP_FINISH, 8'h5a);
        send_item(OP_ABSORB, 8'hff);
        send_item(OP_FINISH, 8'ha5);
        send_item(OP_ABSORB, 8'h61);
        send_item(OP_ABSORB, 8'h62);
        send_item(OP_ABSORB, 8'h63);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_ABSORB, 8'h80);
        send_item(OP_ABSORB, 8'h7f);
        send_item(OP_ABSORB, 8'h01);
        send_item(OP_FINISH, 8'hff);

        while (items_sent < RANDOM_ITEMS) begin
            steady = (items_sent >= 150 && items_sent < 300);
            send_message(pick_length());
        end
        steady = 1'b0;

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.fails == 0)
            $display("md5_hash_engine_test: PASS");
        else
            $display("md5_hash_engine_test: FAIL");
        $finish;
    end

endmodule
